/* rtl/crossbar_route_bfs_defines.svh */
// Assertion macros shared by the crossbar route finder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef CROSSBAR_ROUTE_BFS_DEFINES_SVH
`define CROSSBAR_ROUTE_BFS_DEFINES_SVH

// Check a property on every clock edge outside reset
`define CRB_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition is followed by another in the next cycle
`define CRB_NEXT(lbl, cond, nxt, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

`endif

/* rtl/crb_pkg.sv */
// Types and constants for the crossbar route finder.
// No dependencies; used by crb_engine and crossbar_route_bfs.
package crb_pkg;

   localparam int VERTEX_W = 7;

   // Result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOPATH = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_LONG   = 2'd3;

   // Operation codes
   localparam logic OP_ADD_EDGE = 1'b0;
   localparam logic OP_ROUTE    = 1'b1;

   // Register indexes and reset values
   localparam logic CSR_SPECIAL_FIRST = 1'b0;
   localparam logic CSR_SPECIAL_LAST  = 1'b1;
   localparam logic [VERTEX_W-1:0] SPECIAL_FIRST_RST = 7'd48;
   localparam logic [VERTEX_W-1:0] SPECIAL_LAST_RST  = 7'd79;

   typedef struct packed {
      logic                operation;
      logic [VERTEX_W-1:0] first_vertex;
      logic [VERTEX_W-1:0] second_vertex;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [VERTEX_W-1:0] path_vertex;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] special_first;
      logic [VERTEX_W-1:0] special_last;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_E_RDA,
      S_E_RDB,
      S_E_CHK,
      S_E_WRB,
      S_R_INIT,
      S_R_POP,
      S_R_CUR,
      S_R_CNT,
      S_R_NB,
      S_R_CHK,
      S_B_WR,
      S_B_RD,
      S_O_RD,
      S_O_EMIT
   } state_type;

endpackage

/* rtl/crossbar_route_bfs.sv */
// Top level of the crossbar route finder: register port and sequencer.
// Depends on crb_pkg and crb_engine.
//
// Usage:
//  - Request: drive req_data and raise start; the item is taken at a clock edge
//    with start high and busy low. busy stays high until the item is done.
//  - Results: rsp_valid marks each result for one cycle; the receiver cannot
//    stall. An add-edge item gives one result: ST_OK, or ST_FULL when a list is
//    full or a vertex is out of range.
//  - A route item gives a path, start first, one result per vertex, or one
//    status result. The search scans the neighbour slots of each dequeued
//    vertex one at a time through the single read port of the neighbour
//    memory, then walks back along the path to the start.
//  - Registers: csr_valid/csr_ready write special_first (index 0) and
//    special_last (index 1); write them only while busy is low and no result
//    is pending. csr_ready is always high.
//  - Reset clears the edge counts, used marks and registers (range 48..79);
//    no clearing pass is needed, the block is ready the cycle after reset.
module crossbar_route_bfs #(
   parameter int NUM_VERTICES = 128,
   parameter int MAX_DEGREE   = 32,
   parameter int MAX_PATH     = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  crb_pkg::req_type req_data,
   output logic             rsp_valid,
   output crb_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [6:0]       csr_data
);
   import crb_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SPECIAL_FIRST: cfg_in.special_first = csr_data;
            CSR_SPECIAL_LAST:  cfg_in.special_last  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.special_first <= SPECIAL_FIRST_RST;
         cfg_ff.special_last  <= SPECIAL_LAST_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crb_engine #(
      .NUM_VERTICES (NUM_VERTICES),
      .MAX_DEGREE   (MAX_DEGREE),
      .MAX_PATH     (MAX_PATH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/crb_engine.sv */
// Sequencer and graph memories of the crossbar route finder.
// Depends on crb_pkg and crossbar_route_bfs_defines.svh.
`include "crossbar_route_bfs_defines.svh"

module crb_engine #(
   parameter int NUM_VERTICES = 128,
   parameter int MAX_DEGREE   = 32,
   parameter int MAX_PATH     = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  crb_pkg::req_type req_data,
   input  crb_pkg::cfg_type cfg,
   output logic             busy,
   output logic             rsp_valid,
   output crb_pkg::rsp_type rsp_data
);
   import crb_pkg::*;

   localparam int VW  = $clog2(NUM_VERTICES);
   localparam int SW  = $clog2(MAX_DEGREE);
   localparam int CNW = $clog2(MAX_DEGREE + 1);
   localparam int TW  = $clog2(NUM_VERTICES + 1);
   localparam int PW  = $clog2(MAX_PATH);
   localparam int LW  = $clog2(MAX_PATH + 1);
   localparam int AW  = VW + SW;
   localparam int SD  = NUM_VERTICES * (2 ** SW);
   localparam int CW  = (VW > VERTEX_W) ? VW : VERTEX_W;

   state_type state_ff, state_in;

   logic [VERTEX_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [CNW-1:0]      cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [TW-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [VW-1:0]       cur_ff, cur_in, at_ff, at_in;
   logic [CNW-1:0]      ncnt_ff, ncnt_in, idx_ff, idx_in;
   logic [LW-1:0]       len_ff, len_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [NUM_VERTICES-1:0] seen_ff, seen_in, used_ff, used_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Memories and their ports
   logic [VERTEX_W-1:0] store_mem [SD];
   logic                store_we;
   logic [AW-1:0]       store_wa, store_ra;
   logic [VERTEX_W-1:0] store_wd, store_q_ff;

   logic [CNW-1:0]      cnt_mem [NUM_VERTICES];
   logic [NUM_VERTICES-1:0] cnt_vld_ff;
   logic                cnt_we, cnt_qv_ff;
   logic [VW-1:0]       cnt_wa, cnt_ra;
   logic [CNW-1:0]      cnt_wd, cnt_q_ff, cnt_val;

   logic [VW-1:0]       from_mem [NUM_VERTICES];
   logic                from_we;
   logic [VW-1:0]       from_wa, from_ra, from_wd, from_q_ff;

   logic [VW-1:0]       queue_mem [NUM_VERTICES];
   logic                queue_we;
   logic [VW-1:0]       queue_wa, queue_ra, queue_wd, queue_q_ff;

   logic [VW-1:0]       path_mem [MAX_PATH];
   logic                path_we;
   logic [PW-1:0]       path_wa, path_ra;
   logic [VW-1:0]       path_wd, path_q_ff;

   logic [VW-1:0]       av, bv, nbv;
   logic                a_bad, b_bad, nb_skip, edge_full;

   function automatic logic is_special(input logic [VW-1:0] v, input cfg_type c);
      logic [CW-1:0] vx;
      vx = CW'(v);
      return (vx >= CW'(c.special_first)) && (vx <= CW'(c.special_last));
   endfunction

   assign av        = VW'(a_ff);
   assign bv        = VW'(b_ff);
   assign nbv       = VW'(store_q_ff);
   assign a_bad     = int'(a_ff) >= NUM_VERTICES;
   assign b_bad     = int'(b_ff) >= NUM_VERTICES;
   assign cnt_val   = cnt_qv_ff ? cnt_q_ff : '0;
   assign nb_skip   = (int'(store_q_ff) >= NUM_VERTICES) || seen_ff[nbv] ||
                      (used_ff[nbv] && !is_special(nbv, cfg));
   assign edge_full = a_bad || b_bad ||
                      ((a_ff == b_ff) ? (int'(cnt_a_ff) + 2 > MAX_DEGREE) :
                       ((int'(cnt_a_ff) >= MAX_DEGREE) || (int'(cnt_val) >= MAX_DEGREE)));

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (start) state_in = (req_data.operation == OP_ROUTE) ? S_R_INIT : S_E_RDA;
         S_E_RDA:  state_in = S_E_RDB;
         S_E_RDB:  state_in = S_E_CHK;
         S_E_CHK:  state_in = edge_full ? S_IDLE : S_E_WRB;
         S_E_WRB:  state_in = S_IDLE;
         S_R_INIT: state_in = (a_bad || b_bad || a_ff == b_ff) ? S_IDLE : S_R_POP;
         S_R_POP:  state_in = (head_ff == tail_ff) ? S_IDLE : S_R_CUR;
         S_R_CUR:  state_in = S_R_CNT;
         S_R_CNT:  state_in = S_R_NB;
         S_R_NB:   state_in = (idx_ff >= ncnt_ff) ? S_R_POP : S_R_CHK;
         S_R_CHK: begin
            if (!nb_skip && store_q_ff == b_ff) state_in = S_B_WR;
            else state_in = S_R_NB;
         end
         S_B_WR: begin
            if (at_ff == av) state_in = S_O_RD;
            else if (len_ff == LW'(MAX_PATH - 1)) state_in = S_IDLE;
            else state_in = S_B_RD;
         end
         S_B_RD:   state_in = S_B_WR;
         S_O_RD:   state_in = S_O_EMIT;
         S_O_EMIT: state_in = (pos_ff == '0) ? S_IDLE : S_O_RD;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath, memory ports and results
   always_comb begin
      a_in = a_ff; b_in = b_ff;
      cnt_a_in = cnt_a_ff; cnt_b_in = cnt_b_ff;
      head_in = head_ff; tail_in = tail_ff;
      cur_in = cur_ff; at_in = at_ff;
      ncnt_in = ncnt_ff; idx_in = idx_ff;
      len_in = len_ff; pos_in = pos_ff;
      seen_in = seen_ff; used_in = used_ff;
      rsp_in = '0; rsp_valid_in = 1'b0;
      store_we = 1'b0; store_wa = '0; store_wd = '0; store_ra = '0;
      cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_ra = '0;
      from_we = 1'b0; from_wa = '0; from_wd = '0; from_ra = '0;
      queue_we = 1'b0; queue_wa = '0; queue_wd = '0; queue_ra = '0;
      path_we = 1'b0; path_wa = '0; path_wd = '0; path_ra = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               a_in  = req_data.first_vertex;
               b_in  = req_data.second_vertex;
            end
         end
         S_E_RDA: cnt_ra = av;
         S_E_RDB: begin
            cnt_a_in = cnt_val;
            cnt_ra   = bv;
         end
         S_E_CHK: begin
            if (edge_full) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_FULL;
               rsp_in.last = 1'b1;
            end else begin
               // Append b to the list of a
               store_we = 1'b1;
               store_wa = {av, cnt_a_ff[SW-1:0]};
               store_wd = b_ff;
               cnt_we   = 1'b1;
               cnt_wa   = av;
               cnt_wd   = CNW'(cnt_a_ff + 1'b1);
               cnt_b_in = (a_ff == b_ff) ? CNW'(cnt_a_ff + 1'b1) : cnt_val;
            end
         end
         S_E_WRB: begin
            // Append a to the list of b
            store_we = 1'b1;
            store_wa = {bv, cnt_b_ff[SW-1:0]};
            store_wd = a_ff;
            cnt_we   = 1'b1;
            cnt_wa   = bv;
            cnt_wd   = CNW'(cnt_b_ff + 1'b1);
            rsp_valid_in = 1'b1;
            rsp_in.status = ST_OK;
            rsp_in.last = 1'b1;
         end
         S_R_INIT: begin
            if (a_bad || b_bad || a_ff == b_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_NOPATH;
               rsp_in.last = 1'b1;
            end else begin
               seen_in      = '0;
               seen_in[av]  = 1'b1;
               queue_we     = 1'b1;
               queue_wa     = '0;
               queue_wd     = av;
               head_in      = '0;
               tail_in      = TW'(1);
            end
         end
         S_R_POP: begin
            if (head_ff == tail_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_NOPATH;
               rsp_in.last = 1'b1;
            end else begin
               queue_ra = head_ff[VW-1:0];
               head_in  = TW'(head_ff + 1'b1);
            end
         end
         S_R_CUR: begin
            cur_in = queue_q_ff;
            cnt_ra = queue_q_ff;
         end
         S_R_CNT: begin
            ncnt_in = cnt_val;
            idx_in  = '0;
         end
         S_R_NB: store_ra = {cur_ff, idx_ff[SW-1:0]};
         S_R_CHK: begin
            idx_in = CNW'(idx_ff + 1'b1);
            if (!nb_skip) begin
               from_we      = 1'b1;
               from_wa      = nbv;
               from_wd      = cur_ff;
               seen_in[nbv] = 1'b1;
               if (tail_ff < TW'(NUM_VERTICES)) begin
                  queue_we = 1'b1;
                  queue_wa = tail_ff[VW-1:0];
                  queue_wd = nbv;
                  tail_in  = TW'(tail_ff + 1'b1);
               end
               if (store_q_ff == b_ff) begin
                  at_in  = bv;
                  len_in = '0;
               end
            end
         end
         S_B_WR: begin
            // Record path end first, walking back toward the start
            path_we = 1'b1;
            path_wa = len_ff[PW-1:0];
            path_wd = at_ff;
            if (at_ff == av) begin
               pos_in = len_ff[PW-1:0];
            end else if (len_ff == LW'(MAX_PATH - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_LONG;
               rsp_in.last = 1'b1;
            end else begin
               from_ra = at_ff;
               len_in  = LW'(len_ff + 1'b1);
            end
         end
         S_B_RD: at_in = from_q_ff;
         S_O_RD: path_ra = pos_ff;
         S_O_EMIT: begin
            if (!is_special(path_q_ff, cfg)) used_in[path_q_ff] = 1'b1;
            rsp_valid_in       = 1'b1;
            rsp_in.status      = ST_OK;
            rsp_in.path_vertex = VERTEX_W'(path_q_ff);
            rsp_in.last        = (pos_ff == '0);
            pos_in             = PW'(pos_ff - 1'b1);
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         seen_ff      <= '0;
         cnt_vld_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         seen_ff      <= seen_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         if (cnt_we) cnt_vld_ff[cnt_wa] <= 1'b1;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in;
      cnt_a_ff <= cnt_a_in; cnt_b_ff <= cnt_b_in;
      cur_ff <= cur_in; at_ff <= at_in;
      ncnt_ff <= ncnt_in; idx_ff <= idx_in;
      len_ff <= len_in; pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   // Memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (store_we) store_mem[store_wa] <= store_wd;
      store_q_ff <= store_mem[store_ra];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      cnt_q_ff  <= cnt_mem[cnt_ra];
      cnt_qv_ff <= cnt_vld_ff[cnt_ra];
   end

   always_ff @(posedge clock) begin
      if (from_we) from_mem[from_wa] <= from_wd;
      from_q_ff <= from_mem[from_ra];
   end

   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[queue_wa] <= queue_wd;
      queue_q_ff <= queue_mem[queue_ra];
   end

   always_ff @(posedge clock) begin
      if (path_we) path_mem[path_wa] <= path_wd;
      path_q_ff <= path_mem[path_ra];
   end

   `CRB_CHECK(a_err_vertex_zero, !(rsp_valid_ff && rsp_ff.status != ST_OK && rsp_ff.path_vertex != '0), "error result carries a vertex")
   `CRB_CHECK(a_err_is_last, !(rsp_valid_ff && rsp_ff.status != ST_OK && !rsp_ff.last), "error result not marked last")
   `CRB_CHECK(a_tail_bound, tail_ff <= TW'(NUM_VERTICES) || state_ff == S_IDLE, "queue tail beyond vertex count")
   `CRB_NEXT(a_start_leaves_idle, state_ff == S_IDLE && start, state_ff != S_IDLE, "accepted item did not start")

endmodule
